// ===== rtl/uri_percent_decoder_utf8_assert.svh =====
// ----------------------------------------------------------------------------
// URI percent decoder assertion macros
// Shared assertion forms for the decoder; they compile to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef URI_PERCENT_DECODER_UTF8_ASSERT_SVH
`define URI_PERCENT_DECODER_UTF8_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define UPDU8_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define UPDU8_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define UPDU8_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define UPDU8_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/updu8_pkg.sv =====
// ----------------------------------------------------------------------------
// URI percent decoder package
// Beat types, parse phases and the character tables of the decoder.
// ----------------------------------------------------------------------------
package updu8_pkg;

  localparam logic [7:0] PERCENT_CHAR = 8'h25;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] dec_byte;
    logic       byte_valid;
    logic       string_end;
    logic       malformed;
    logic       run_last;
  } out_beat_t;

  // Results caused by one input beat: n of them, sharing the flags.
  typedef struct packed {
    logic [1:0]       n;
    logic [2:0][7:0]  bytes;
    logic             byte_valid;
    logic             string_end;
    logic             malformed;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] count;
  } lead_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic reserved_char(input logic [7:0] c);
    return c inside {8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B,
                     8'h24, 8'h2C, 8'h23};
  endfunction

  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t l;
    l.ok    = 1'b1;
    l.count = 2'd0;
    if (b[7] == 1'b0) begin
      l.count = 2'd0;
    end else if ((b & 8'hE0) == 8'hC0) begin
      l.count = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      l.count = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      l.count = 2'd3;
    end else begin
      l.ok = 1'b0;
    end
    return l;
  endfunction

endpackage

// ===== rtl/updu8_parse.sv =====
// ----------------------------------------------------------------------------
// URI percent decoder parse stage
// Holds the escape and UTF-8 sequence state and works out the results of one
// input beat; the state advances when the beat is passed on.
// ----------------------------------------------------------------------------
module updu8_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  updu8_pkg::in_beat_t beat,
  input  logic                keep_reserved,
  output updu8_pkg::bundle_t  res
);

  updu8_pkg::phase_t phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic [7:0] first_hex_char, first_hex_char_next;
  logic [1:0] pending, pending_next;
  logic       error_latch, error_latch_next;

  updu8_pkg::hex_t  hx;
  updu8_pkg::lead_t ld;
  logic [7:0]       dec;
  logic [7:0]       c;

  assign c   = beat.in_byte;
  assign hx  = updu8_pkg::hex_decode(c);
  assign dec = {high_nibble, hx.value};
  assign ld  = updu8_pkg::lead_decode(dec);

  always_comb begin
    phase_next          = phase;
    high_nibble_next    = high_nibble;
    first_hex_char_next = first_hex_char;
    pending_next        = pending;
    error_latch_next    = error_latch;
    res                 = '0;
    res.byte_valid      = 1'b1;
    if (!error_latch) begin
      case (phase)
        updu8_pkg::PH_IDLE: begin
          if (c == updu8_pkg::PERCENT_CHAR) begin
            phase_next = updu8_pkg::PH_HIGH;
          end else if (pending != 2'd0) begin
            error_latch_next = 1'b1;
          end else begin
            res.n        = 2'd1;
            res.bytes[0] = c;
          end
        end
        updu8_pkg::PH_HIGH: begin
          if (!hx.ok) begin
            error_latch_next = 1'b1;
          end else begin
            high_nibble_next    = hx.value;
            first_hex_char_next = c;
            phase_next          = updu8_pkg::PH_LOW;
          end
        end
        updu8_pkg::PH_LOW: begin
          phase_next = updu8_pkg::PH_IDLE;
          if (!hx.ok) begin
            error_latch_next = 1'b1;
          end else if (pending != 2'd0) begin
            if (dec[7:6] != 2'b10) begin
              error_latch_next = 1'b1;
            end else begin
              res.n        = 2'd1;
              res.bytes[0] = dec;
              pending_next = pending - 2'd1;
            end
          end else if (keep_reserved && !dec[7] && updu8_pkg::reserved_char(dec)) begin
            res.n        = 2'd3;
            res.bytes[0] = updu8_pkg::PERCENT_CHAR;
            res.bytes[1] = first_hex_char;
            res.bytes[2] = c;
          end else if (!ld.ok) begin
            error_latch_next = 1'b1;
          end else begin
            res.n        = 2'd1;
            res.bytes[0] = dec;
            pending_next = ld.count;
          end
        end
        default: begin
          phase_next = updu8_pkg::PH_IDLE;
        end
      endcase
    end
    if (error_latch_next) begin
      res.n = 2'd0;
    end
    if (beat.is_last) begin
      if (phase_next != updu8_pkg::PH_IDLE || pending_next != 2'd0) begin
        error_latch_next = 1'b1;
      end
      if (error_latch_next) begin
        res            = '0;
        res.n          = 2'd1;
        res.string_end = 1'b1;
        res.malformed  = 1'b1;
      end else if (res.n == 2'd0) begin
        res            = '0;
        res.n          = 2'd1;
        res.string_end = 1'b1;
      end else begin
        res.string_end = 1'b1;
      end
      phase_next          = updu8_pkg::PH_IDLE;
      high_nibble_next    = 4'd0;
      first_hex_char_next = 8'd0;
      pending_next        = 2'd0;
      error_latch_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= updu8_pkg::PH_IDLE;
      high_nibble    <= 4'd0;
      first_hex_char <= 8'd0;
      pending        <= 2'd0;
      error_latch    <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      high_nibble    <= high_nibble_next;
      first_hex_char <= first_hex_char_next;
      pending        <= pending_next;
      error_latch    <= error_latch_next;
    end
  end

endmodule

// ===== rtl/uri_percent_decoder_utf8.sv =====
// ----------------------------------------------------------------------------
// URI percent decoder with UTF-8 checking
// Decodes a percent-encoded string one byte per beat and flags bad strings.
// ----------------------------------------------------------------------------
// Each input beat is registered, parsed by short logic and its results are
// loaded into a result register that is read out one beat per cycle while
// out_stall is low, so plain text and ordinary escapes (at most one result
// per byte) stream at one byte per clock; a reserved escape kept verbatim
// yields three results and holds the result register until all are read.
// Input passes the input and result registers. A malformed string produces no
// bytes after the fault and ends with a single beat carrying malformed.
module uri_percent_decoder_utf8 (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  updu8_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output updu8_pkg::out_beat_t out_data
);

`include "uri_percent_decoder_utf8_assert.svh"

  logic                keep_reserved;
  logic                in_reg_valid;
  updu8_pkg::in_beat_t in_reg;
  updu8_pkg::bundle_t  res;
  logic                bund_valid;
  logic [2:0][7:0]     bund_bytes;
  logic                bund_bv;
  logic                bund_end;
  logic                bund_bad;
  logic [1:0]          last_idx;
  logic [1:0]          idx;
  logic                out_take;
  logic                bund_done;
  logic                move;
  logic                in_take;
  logic                at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_reserved <= 1'b0;
    end else if (cfg_we) begin
      keep_reserved <= cfg_wdata;
    end
  end

  updu8_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .step          (move),
    .beat          (in_reg),
    .keep_reserved (keep_reserved),
    .res           (res)
  );

  assign at_last   = (idx == last_idx);
  assign out_take  = out_valid && !out_stall;
  assign bund_done = out_take && at_last;
  assign move      = in_reg_valid && (!bund_valid || bund_done || res.n == 2'd0);
  assign in_stall  = in_reg_valid && !move;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (move) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bund_valid <= 1'b0;
      idx        <= 2'd0;
    end else if (move && res.n != 2'd0) begin
      bund_valid <= 1'b1;
      idx        <= 2'd0;
    end else if (bund_done) begin
      bund_valid <= 1'b0;
      idx        <= 2'd0;
    end else if (out_take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move && res.n != 2'd0) begin
      bund_bytes <= res.bytes;
      bund_bv    <= res.byte_valid;
      bund_end   <= res.string_end;
      bund_bad   <= res.malformed;
      last_idx   <= res.n - 2'd1;
    end
  end

  assign out_valid = bund_valid;

  always_comb begin
    case (idx)
      2'd0:    out_data.dec_byte = bund_bytes[0];
      2'd1:    out_data.dec_byte = bund_bytes[1];
      2'd2:    out_data.dec_byte = bund_bytes[2];
      default: out_data.dec_byte = 8'd0;
    endcase
    out_data.byte_valid = bund_bv;
    out_data.string_end = bund_end && at_last;
    out_data.malformed  = bund_bad && at_last;
    out_data.run_last   = at_last;
  end

  `UPDU8_ASSERT_IMPLY(a_idx_in_range, clk, rst, out_valid, idx <= last_idx)
  `UPDU8_ASSERT_IMPLY(a_bad_is_end, clk, rst, out_valid && out_data.malformed,
                      out_data.string_end && !out_data.byte_valid)
  `UPDU8_ASSERT_NEXT(a_run_continues, clk, rst, out_take && !at_last, out_valid)
  `UPDU8_ASSERT_IMPLY(a_no_load_over, clk, rst, move && res.n != 2'd0,
                      !bund_valid || bund_done)

endmodule
